[rtl/ole_pkg.sv]
// Shared types, constants and codes of the ordered list engine.
`timescale 1ns / 1ps
package ole_pkg;

  // Number of list entries, one cell each.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 8;
  localparam int POS_W    = 8;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 3;
  localparam int LEN_W    = 5;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Request kinds carried on the input tuser.
  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_SORT   = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FEW      = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // Commands broadcast from the sequencer to the chain.
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_LOAD_AT   = 3'd1,
    CMD_MARK      = 3'd2,
    CMD_PROP      = 3'd3,
    CMD_SORT_EVEN = 3'd4,
    CMD_SORT_ODD  = 3'd5,
    CMD_SHIFT_DEL = 3'd6,
    CMD_ROTATE    = 3'd7
  } chain_cmd_e;

  // Per-cell operations chosen by the chain.
  typedef enum logic [3:0] {
    CA_KEEP  = 4'd0,
    CA_LOAD  = 4'd1,
    CA_LEFT  = 4'd2,
    CA_RIGHT = 4'd3,
    CA_WRAP  = 4'd4,
    CA_MIN_R = 4'd5,
    CA_MAX_L = 4'd6,
    CA_MARK  = 4'd7,
    CA_CLEAR = 4'd8,
    CA_PROP  = 4'd9
  } cell_act_e;

  // Control bundle from the sequencer to the chain.
  typedef struct packed {
    chain_cmd_e               cmd;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         target;
    logic [CNT_W-1:0]         count;
  } chain_ctrl_t;

endpackage

[rtl/ole_cell.sv]
// One list cell: a stored value and a delete mark, updated from its neighbors.
`timescale 1ns / 1ps
module ole_cell (
  input  logic                              clk_i,
  input  ole_pkg::cell_act_e                act_i,
  input  logic signed [ole_pkg::DATA_W-1:0] value_i,
  input  logic signed [ole_pkg::DATA_W-1:0] left_data_i,
  input  logic signed [ole_pkg::DATA_W-1:0] right_data_i,
  input  logic signed [ole_pkg::DATA_W-1:0] wrap_data_i,
  input  logic                              left_del_i,
  output logic signed [ole_pkg::DATA_W-1:0] data_o,
  output logic                              del_o
);
  import ole_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     del_q, del_d;

  // Select the next value and mark for the requested operation.
  always_comb begin
    data_d = data_q;
    del_d  = del_q;
    case (act_i)
      CA_LOAD:  data_d = value_i;
      CA_LEFT:  data_d = left_data_i;
      CA_RIGHT: data_d = right_data_i;
      CA_WRAP:  data_d = wrap_data_i;
      CA_MIN_R: data_d = (right_data_i < data_q) ? right_data_i : data_q;
      CA_MAX_L: data_d = (left_data_i > data_q) ? left_data_i : data_q;
      CA_MARK:  del_d  = (data_q == value_i);
      CA_CLEAR: del_d  = 1'b0;
      CA_PROP:  del_d  = del_q | left_del_i;
      default:  data_d = data_q;
    endcase
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    del_q  <= del_d;
  end

  assign data_o = data_q;
  assign del_o  = del_q;

endmodule

[rtl/ole_chain.sv]
// Row of list cells with the per-cell decode of broadcast commands.
`timescale 1ns / 1ps
module ole_chain (
  input  logic                              clk_i,
  input  ole_pkg::chain_ctrl_t              ctrl_i,
  output logic signed [ole_pkg::DATA_W-1:0] head_o,
  output logic                              found_o
);
  import ole_pkg::*;

  logic signed [DATA_W-1:0] data   [CAPACITY];
  logic                     del    [CAPACITY];
  logic signed [DATA_W-1:0] left_d [CAPACITY];
  logic signed [DATA_W-1:0] right_d[CAPACITY];
  logic                     left_m [CAPACITY];
  cell_act_e                act    [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IDX_W-1:0] IDX   = IDX_W'(i);
    localparam logic [CNT_W-1:0] CUR   = CNT_W'(i);
    localparam logic [CNT_W-1:0] NXT   = CNT_W'(i + 1);
    localparam logic             PAR   = (i % 2) == 1;
    localparam logic             FIRST = (i == 0);

    // Neighbor wiring; the ends take their own value or nothing.
    if (i == 0) begin : g_lo
      assign left_d[i] = '0;
      assign left_m[i] = 1'b0;
    end else begin : g_lo
      assign left_d[i] = data[i-1];
      assign left_m[i] = del[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_d[i] = data[i];
    end else begin : g_hi
      assign right_d[i] = data[i+1];
    end

    // Decode the broadcast command for this cell position.
    always_comb begin
      act[i] = CA_KEEP;
      case (ctrl_i.cmd)
        CMD_LOAD_AT: begin
          if (IDX == ctrl_i.target) act[i] = CA_LOAD;
          else if (IDX > ctrl_i.target) act[i] = CA_LEFT;
        end
        CMD_MARK: act[i] = (CUR < ctrl_i.count) ? CA_MARK : CA_CLEAR;
        CMD_PROP: act[i] = CA_PROP;
        CMD_SORT_EVEN, CMD_SORT_ODD: begin
          // Lower cell of a pair keeps the minimum, upper cell the maximum.
          if (PAR == (ctrl_i.cmd == CMD_SORT_ODD)) begin
            if (NXT < ctrl_i.count) act[i] = CA_MIN_R;
          end else if (!FIRST && CUR < ctrl_i.count) begin
            act[i] = CA_MAX_L;
          end
        end
        CMD_SHIFT_DEL: act[i] = del[i] ? CA_RIGHT : CA_KEEP;
        CMD_ROTATE: begin
          if (NXT < ctrl_i.count) act[i] = CA_RIGHT;
          else if (NXT == ctrl_i.count) act[i] = CA_WRAP;
        end
        default: act[i] = CA_KEEP;
      endcase
    end

    ole_cell u_cell (
      .clk_i        (clk_i),
      .act_i        (act[i]),
      .value_i      (ctrl_i.value),
      .left_data_i  (left_d[i]),
      .right_data_i (right_d[i]),
      .wrap_data_i  (data[0]),
      .left_del_i   (left_m[i]),
      .data_o       (data[i]),
      .del_o        (del[i])
    );
  end

  // The front cell feeds read-out; the far end tells whether a match exists.
  assign head_o  = data[0];
  assign found_o = del[CAPACITY-1];

endmodule

[rtl/ordered_list_engine.sv]
// Top level of the ordered list engine: request sequencer, cell chain and result register.
`timescale 1ns / 1ps
// Keeps up to CAPACITY signed bytes in a row of cells and serves one request at a
// time, taken on the slave stream with the action on tuser. Append, insert and
// unused actions give their single result from the execute state through the
// output register. Remove marks matching cells and then passes the mark down the
// chain one cell per cycle. Sort runs CAPACITY odd-even compare rounds over
// neighboring cells. Read-out rotates the stored values through the front cell,
// one result per cycle while the master side takes them. A result waits in an
// output register, and a stalled master side stalls the sequencer only when it
// has the next result to hand over.
module ordered_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request: tdata = value[7:0], position[15:8]; tuser = action[2:0].
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  input  logic [2:0]  s_axis_tuser_i,
  // Result: tdata = status[2:0], length[7:3], element[15:8]; tlast = last.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import ole_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_SCAN = 6'b000100,
    S_SORT = 6'b001000,
    S_DONE = 6'b010000,
    S_READ = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [ACT_W-1:0]         act_q;
  logic signed [DATA_W-1:0] val_q;
  logic [POS_W-1:0]         pos_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         step_q, step_d;
  logic [CNT_W-1:0]         step_nxt;
  logic [POS_W-1:0]         pos_m1;
  logic [IDX_W-1:0]         ins_at;

  logic                     out_valid_q;
  logic [STAT_W-1:0]        out_status_q;
  logic [LEN_W-1:0]         out_length_q;
  logic signed [DATA_W-1:0] out_element_q;
  logic                     out_last_q;

  logic                     slot_free;
  logic                     emit;
  status_e                  e_status;
  logic signed [DATA_W-1:0] e_element;
  logic                     e_last;
  logic [LEN_W-1:0]         e_length;

  chain_ctrl_t              ctrl;
  logic signed [DATA_W-1:0] head;
  logic                     found;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign step_nxt        = step_q + CNT_W'(1);

  // Insert index is position - 1 clamped to the tail.
  assign pos_m1 = pos_q - POS_W'(1);
  assign ins_at = (32'(pos_m1) > 32'(count_q)) ? count_q[IDX_W-1:0] : pos_m1[IDX_W-1:0];

  // Sequencer: decide the chain command, the next state and any result.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    ctrl.cmd    = CMD_NONE;
    ctrl.value  = val_q;
    ctrl.target = count_q[IDX_W-1:0];
    ctrl.count  = count_q;
    emit        = 1'b0;
    e_status    = ST_OK;
    e_element   = '0;
    e_last      = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (act_q)
          ACT_APPEND: begin
            if (slot_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
              if (count_q == CAP_CNT) begin
                e_status = ST_FULL;
              end else begin
                ctrl.cmd = CMD_LOAD_AT;
                count_d  = count_q + CNT_W'(1);
              end
            end
          end
          ACT_INSERT: begin
            if (slot_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
              if (pos_q == '0) begin
                e_status = ST_BADPOS;
              end else if (count_q == CAP_CNT) begin
                e_status = ST_FULL;
              end else begin
                ctrl.cmd    = CMD_LOAD_AT;
                ctrl.target = ins_at;
                count_d     = count_q + CNT_W'(1);
              end
            end
          end
          ACT_REMOVE: begin
            if (count_q == '0) begin
              if (slot_free) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
                state_d  = S_IDLE;
              end
            end else begin
              ctrl.cmd = CMD_MARK;
              step_d   = CNT_W'(1);
              state_d  = S_SCAN;
            end
          end
          ACT_SORT: begin
            if (count_q < CNT_W'(2)) begin
              if (slot_free) begin
                emit     = 1'b1;
                e_status = ST_FEW;
                state_d  = S_IDLE;
              end
            end else begin
              step_d  = '0;
              state_d = S_SORT;
            end
          end
          ACT_READ: begin
            if (count_q == '0) begin
              if (slot_free) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
                state_d  = S_IDLE;
              end
            end else begin
              step_d  = '0;
              state_d = S_READ;
            end
          end
          default: begin
            if (slot_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        // Spread the first match toward the far end of the chain.
        ctrl.cmd = CMD_PROP;
        if (step_q == CAP_CNT - CNT_W'(1)) state_d = S_DONE;
        else step_d = step_nxt;
      end
      S_SORT: begin
        ctrl.cmd = step_q[0] ? CMD_SORT_ODD : CMD_SORT_EVEN;
        if (step_q == CAP_CNT - CNT_W'(1)) state_d = S_DONE;
        else step_d = step_nxt;
      end
      S_DONE: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (act_q == ACT_REMOVE) begin
            if (found) begin
              ctrl.cmd = CMD_SHIFT_DEL;
              count_d  = count_q - CNT_W'(1);
            end else begin
              e_status = ST_NOTFOUND;
            end
          end
        end
      end
      S_READ: begin
        if (slot_free) begin
          ctrl.cmd  = CMD_ROTATE;
          emit      = 1'b1;
          e_element = head;
          e_last    = (step_nxt == count_q);
          if (e_last) state_d = S_IDLE;
          else step_d = step_nxt;
        end
      end
      default: state_d = S_IDLE;
    endcase
    e_length = LEN_W'(count_d);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      if (emit) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      act_q <= s_axis_tuser_i;
      val_q <= $signed(s_axis_tdata_i[DATA_W-1:0]);
      pos_q <= s_axis_tdata_i[DATA_W+POS_W-1:DATA_W];
    end
    if (emit) begin
      out_status_q  <= e_status;
      out_length_q  <= e_length;
      out_element_q <= e_element;
      out_last_q    <= e_last;
    end
  end

  ole_chain u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .head_o  (head),
    .found_o (found)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_element_q, out_length_q, out_status_q};
  assign m_axis_tlast_o  = out_last_q;

  // The stored count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CAP_CNT)
    else $error("list count above capacity");

  // A new result never overwrites one that the master side has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_valid_q) |-> m_axis_tready_i)
    else $error("result register overwritten");

  // The read-out index stays inside the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (step_q < count_q))
    else $error("read-out index past the tail");

  // The count moves only while a request is being finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EXEC && state_q != S_DONE) |=> $stable(count_q))
    else $error("count changed outside request completion");

  // The final read-out result returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && emit && e_last) |=> (state_q == S_IDLE))
    else $error("read-out did not end after the last value");

endmodule
